// File: hdl/rcfr_pkg.sv
// Package: item types, frame constants and internal handoff structs for the RC frame receiver
`timescale 1ns / 1ps
`default_nettype none
package rcfr_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [15:0] CKSUM_INIT = 16'hFFFF;
  localparam int          POS_W      = 6;
  localparam int          IDX_W      = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] channel_index;
    logic [15:0]      channel_value;
    logic             frame_status;
    logic             last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } frame_evt_t;

  typedef struct packed {
    logic             valid;
    logic             hi;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } stage_wr_t;

endpackage
`default_nettype wire

// File: hdl/rcfr_parser.sv
// Header hunt, byte position tracking and running checksum for one frame
`timescale 1ns / 1ps
`default_nettype none
module rcfr_parser #(
  parameter int CHANNEL_COUNT = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire rcfr_pkg::in_item_t item,
  output rcfr_pkg::frame_evt_t   evt_o,
  output rcfr_pkg::stage_wr_t    wr_o,
  output logic                   at_last_o
);

  localparam int DATA_END  = 2 + 2 * CHANNEL_COUNT;
  localparam int FRAME_LEN = DATA_END + 2;

  logic [rcfr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                cks_r, cks_nxt;
  logic [7:0]                 low_r, low_nxt;
  logic [rcfr_pkg::POS_W-1:0] off;
  logic [7:0]                 b;

  assign b         = item.rx_byte;
  assign off       = pos_r - rcfr_pkg::POS_W'(2);
  assign at_last_o = (pos_r == rcfr_pkg::POS_W'(FRAME_LEN - 1));

  always_comb begin
    pos_nxt     = pos_r;
    cks_nxt     = cks_r;
    low_nxt     = low_r;
    evt_o.valid = 1'b0;
    evt_o.ok    = ({b, low_r} == cks_r);
    wr_o.valid  = 1'b0;
    wr_o.hi     = off[0];
    wr_o.idx    = off[rcfr_pkg::IDX_W:1];
    wr_o.data   = b;
    if (fire) begin
      priority if (item.flush) begin
        pos_nxt = '0;
      end else if (pos_r == '0) begin
        if (b == rcfr_pkg::HDR_FIRST) begin
          cks_nxt = rcfr_pkg::CKSUM_INIT - {8'd0, b};
          pos_nxt = rcfr_pkg::POS_W'(1);
        end
      end else if (pos_r == rcfr_pkg::POS_W'(1)) begin
        if (b == rcfr_pkg::HDR_SECOND) begin
          cks_nxt = cks_r - {8'd0, b};
          pos_nxt = rcfr_pkg::POS_W'(2);
        end else begin
          pos_nxt = '0;
        end
      end else if (pos_r < rcfr_pkg::POS_W'(DATA_END)) begin
        wr_o.valid = 1'b1;
        cks_nxt    = cks_r - {8'd0, b};
        pos_nxt    = pos_r + rcfr_pkg::POS_W'(1);
      end else if (pos_r == rcfr_pkg::POS_W'(DATA_END)) begin
        low_nxt = b;
        pos_nxt = pos_r + rcfr_pkg::POS_W'(1);
      end else if (at_last_o) begin
        evt_o.valid = 1'b1;
        pos_nxt     = '0;
      end else begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cks_r <= rcfr_pkg::CKSUM_INIT;
    end else begin
      pos_r <= pos_nxt;
      cks_r <= cks_nxt;
    end
    low_r <= low_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= rcfr_pkg::POS_W'(FRAME_LEN - 1))
    else $error("byte position beyond frame");
  a_flush_resync: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.flush |=> pos_r == '0)
    else $error("flush did not restart the hunt");
  a_end_resync: assert property (@(posedge clk) disable iff (!rst_n)
    fire && at_last_o |=> pos_r == '0)
    else $error("frame end did not restart the hunt");

endmodule
`default_nettype wire

// File: hdl/rcfr_drain.sv
// Channel staging, frame snapshot and result drain into the output register
`timescale 1ns / 1ps
`default_nettype none
module rcfr_drain #(
  parameter int CHANNEL_COUNT = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rcfr_pkg::stage_wr_t  wr_i,
  input  wire rcfr_pkg::frame_evt_t evt_i,
  output logic                      ready_o,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output rcfr_pkg::out_item_t       out_item
);

  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic [15:0] staged_r [CHANNEL_COUNT];
  logic [15:0] shadow_r [CHANNEL_COUNT];
  logic                       busy_r, busy_nxt;
  logic                       err_r, err_nxt;
  logic [rcfr_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  rcfr_pkg::out_item_t        out_item_r, out_item_nxt;
  logic                       load;
  logic                       last_ch;

  assign ready_o   = !busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign last_ch   = (idx_r == rcfr_pkg::IDX_W'(CHANNEL_COUNT - 1));

  always_comb begin
    busy_nxt      = busy_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (err_r) begin
        out_item_nxt.channel_index = '0;
        out_item_nxt.channel_value = '0;
        out_item_nxt.frame_status  = 1'b1;
        out_item_nxt.last_of_frame = 1'b1;
        busy_nxt                   = 1'b0;
      end else begin
        out_item_nxt.channel_index = idx_r;
        out_item_nxt.channel_value = shadow_r[idx_r[CH_W-1:0]];
        out_item_nxt.frame_status  = 1'b0;
        out_item_nxt.last_of_frame = last_ch;
        if (last_ch) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + rcfr_pkg::IDX_W'(1);
        end
      end
    end
    if (evt_i.valid) begin
      busy_nxt = 1'b1;
      err_nxt  = !evt_i.ok;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.valid) begin
      if (wr_i.hi) begin
        staged_r[wr_i.idx[CH_W-1:0]][15:8] <= wr_i.data;
      end else begin
        staged_r[wr_i.idx[CH_W-1:0]][7:0] <= wr_i.data;
      end
    end
    if (evt_i.valid) begin
      shadow_r <= staged_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      err_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      err_r       <= err_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  a_evt_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    evt_i.valid |-> !busy_r)
    else $error("frame completed while previous frame still draining");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !err_r |-> idx_r <= rcfr_pkg::IDX_W'(CHANNEL_COUNT - 1))
    else $error("drain index out of range");
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r && out_item_r.last_of_frame)
    else $error("drain ended without a marked last item");

endmodule
`default_nettype wire

// File: hdl/rc_channel_frame_receiver.sv
// Top level: RC channel frame receiver with byte input and channel result output
// Takes one received byte per cycle and gives at most one result per cycle. A 32-byte
// frame (two header bytes 0x20 0x40, CHANNEL_COUNT little-endian channel words, a
// little-endian checksum of 0xFFFF minus all earlier bytes) yields CHANNEL_COUNT channel
// items, the last one marked, or a single checksum-error item. Channel bytes are staged
// as they arrive and the whole set is copied to a snapshot when the checksum byte lands,
// so the next frame is received while the previous one drains. Input stalls only when
// a checksum byte arrives while the snapshot still drains; flush drops a partial frame
// and restarts the hunt.
`timescale 1ns / 1ps
`default_nettype none
module rc_channel_frame_receiver #(
  parameter int CHANNEL_COUNT = 14
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rcfr_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rcfr_pkg::out_item_t      out_item
);

  rcfr_pkg::frame_evt_t evt;
  rcfr_pkg::stage_wr_t  wr;
  logic                 at_last;
  logic                 drain_ready;
  logic                 in_fire;

  assign in_stall = at_last && !drain_ready;
  assign in_fire  = in_valid && !in_stall;

  rcfr_parser #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .item     (in_item),
    .evt_o    (evt),
    .wr_o     (wr),
    .at_last_o(at_last)
  );

  rcfr_drain #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_i     (wr),
    .evt_i    (evt),
    .ready_o  (drain_ready),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
